// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the HSV pixel generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Concurrent check, switched off while reset is high.
`define HSVG_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also runs through reset.
`define HSVG_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define HSVG_ASSERT(lbl, clk, rst, prop, msg)

`define HSVG_ASSERT_NR(lbl, clk, prop, msg)

`endif

`endif

// ===== rtl/core/hsvg_pkg.sv =====
// Types, widths, constants and the divider step for the HSV pixel generator.
`timescale 1ns / 1ps

package hsvg_pkg;

  // Field and datapath widths
  localparam int COORD_BITS = 12;
  localparam int SIZE_BITS  = 13;
  localparam int CHAN_BITS  = 8;
  localparam int FRAC_BITS  = 13;
  localparam int HUE_BITS   = 16;
  localparam int V_BITS     = 8;
  localparam int SIX_BITS   = COORD_BITS + 3;
  localparam int FULL_BITS  = V_BITS + FRAC_BITS;
  localparam int PROD_BITS  = V_BITS + FULL_BITS;

  // Divider pipeline shape: quotient bits resolved per stage
  localparam int DIV_STAGES = 4;
  localparam int HUE_STEPS  = HUE_BITS / DIV_STAGES;
  localparam int V_STEPS    = V_BITS / DIV_STAGES;

  // Constants
  localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(256);
  localparam logic [CHAN_BITS-1:0] CHAN_MAX   = CHAN_BITS'(255);
  localparam logic [FULL_BITS-1:0] FULL_SCALE = FULL_BITS'(255 * 8192);

  // Size register indexes on the write port
  localparam logic REG_FIELD_WIDTH  = 1'b0;
  localparam logic REG_FIELD_HEIGHT = 1'b1;

  // Hue sectors, in order round the colour circle
  localparam logic [2:0] SEC_RED_YELLOW    = 3'd0;
  localparam logic [2:0] SEC_YELLOW_GREEN  = 3'd1;
  localparam logic [2:0] SEC_GREEN_CYAN    = 3'd2;
  localparam logic [2:0] SEC_CYAN_BLUE     = 3'd3;
  localparam logic [2:0] SEC_BLUE_MAGENTA  = 3'd4;
  localparam logic [2:0] SEC_MAGENTA_RED   = 3'd5;

  typedef struct packed {
    logic [COORD_BITS-1:0] column;
    logic [COORD_BITS-1:0] row;
  } pixel_in_t;

  typedef struct packed {
    logic [CHAN_BITS-1:0] red;
    logic [CHAN_BITS-1:0] green;
    logic [CHAN_BITS-1:0] blue;
  } pixel_out_t;

  // Effective field size (zero already mapped to one)
  typedef struct packed {
    logic [SIZE_BITS-1:0] width;
    logic [SIZE_BITS-1:0] height;
  } dims_t;

  // Divider state carried down the pipeline
  typedef struct packed {
    logic [SIZE_BITS-1:0] hrem;
    logic [HUE_BITS-1:0]  hq;
    logic [HUE_BITS-1:0]  tail;
    logic [SIZE_BITS-1:0] vrem;
    logic [V_BITS-1:0]    vq;
  } div_t;

  // One restoring division step: returns {quotient bit, new remainder}.
  // The remainder stays below the divisor, so it fits SIZE_BITS.
  function automatic logic [SIZE_BITS:0] div_step(input logic [SIZE_BITS-1:0] rem,
                                                  input logic din,
                                                  input logic [SIZE_BITS-1:0] d);
    logic [SIZE_BITS:0] t;
    logic [SIZE_BITS:0] diff;
    t    = {rem, din};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      div_step = {1'b1, diff[SIZE_BITS-1:0]};
    end else begin
      div_step = {1'b0, t[SIZE_BITS-1:0]};
    end
  endfunction

endpackage

// ===== rtl/core/hsvg_div_stage.sv =====
// One register stage of the pipelined hue and brightness dividers.
`timescale 1ns / 1ps

module hsvg_div_stage (
  input  logic             clk,
  input  logic             rst,
  input  hsvg_pkg::dims_t  dims,
  input  logic             in_valid,
  output logic             in_ready,
  input  hsvg_pkg::div_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output hsvg_pkg::div_t   out_data
);

  logic                           vld;
  hsvg_pkg::div_t                 data;
  hsvg_pkg::div_t                 data_next;
  logic [hsvg_pkg::SIZE_BITS:0]   step_h;
  logic [hsvg_pkg::SIZE_BITS:0]   step_v;

  // Resolve the next quotient bits of both divisions
  always_comb begin
    data_next = in_data;
    step_h    = '0;
    step_v    = '0;
    for (int i = 0; i < hsvg_pkg::HUE_STEPS; i++) begin
      step_h = hsvg_pkg::div_step(data_next.hrem, data_next.tail[hsvg_pkg::HUE_BITS-1],
                                  dims.width);
      data_next.hq   = {data_next.hq[hsvg_pkg::HUE_BITS-2:0], step_h[hsvg_pkg::SIZE_BITS]};
      data_next.hrem = step_h[hsvg_pkg::SIZE_BITS-1:0];
      data_next.tail = {data_next.tail[hsvg_pkg::HUE_BITS-2:0], 1'b0};
    end
    for (int j = 0; j < hsvg_pkg::V_STEPS; j++) begin
      step_v = hsvg_pkg::div_step(data_next.vrem, 1'b0, dims.height);
      data_next.vq   = {data_next.vq[hsvg_pkg::V_BITS-2:0], step_v[hsvg_pkg::SIZE_BITS]};
      data_next.vrem = step_v[hsvg_pkg::SIZE_BITS-1:0];
    end
  end

  // Advance when empty or when the next stage takes the request
  assign in_ready = !vld || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= data_next;
    end
  end

  assign out_valid = vld;
  assign out_data  = data;

endmodule

// ===== rtl/core/hsvg_colour.sv =====
// Saturation, sector products and channel selection: three register stages.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module hsvg_colour (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  hsvg_pkg::div_t       in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output hsvg_pkg::pixel_out_t out_data
);

  localparam int CB = hsvg_pkg::CHAN_BITS;
  localparam int VB = hsvg_pkg::V_BITS;
  localparam int FB = hsvg_pkg::FRAC_BITS;
  localparam int LB = hsvg_pkg::FULL_BITS;
  localparam int PB = hsvg_pkg::PROD_BITS;

  // Stage A: value, saturation, fraction, sector
  logic          a_vld;
  logic          a_rdy;
  logic [VB-1:0] a_v;
  logic [CB-1:0] a_s;
  logic [FB-1:0] a_f;
  logic [2:0]    a_sector;
  logic [2*VB-1:0] vv;

  // Stage B: s*f, 255-s and the low product
  logic          b_vld;
  logic          b_rdy;
  logic [VB-1:0] b_v;
  logic [LB-1:0] b_sf;
  logic [CB-1:0] b_om;
  logic [CB-1:0] b_p1;
  logic [2:0]    b_sector;
  logic [LB-1:0] sf;
  logic [CB-1:0] om;
  logic [2*VB-1:0] p1_prod;

  // Stage C: output register
  logic                 c_vld;
  logic                 c_rdy;
  hsvg_pkg::pixel_out_t c_pix;
  hsvg_pkg::pixel_out_t pix_next;
  logic [LB-1:0] d2;
  logic [LB-1:0] d3;
  logic [PB-1:0] prod2;
  logic [PB-1:0] prod3;
  logic [CB-1:0] p2;
  logic [CB-1:0] p3;

  // Ready chain: each stage moves on when empty or when drained downstream
  assign c_rdy    = !c_vld || out_ready;
  assign b_rdy    = !b_vld || c_rdy;
  assign a_rdy    = !a_vld || b_rdy;
  assign in_ready = a_rdy;

  // Stage A logic: saturation falls with brightness squared
  assign vv = {{VB{1'b0}}, in_data.vq} * {{VB{1'b0}}, in_data.vq};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (a_rdy) begin
      a_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && in_valid) begin
      a_v      <= in_data.vq;
      a_s      <= hsvg_pkg::CHAN_MAX - vv[2*VB-1:VB];
      a_f      <= in_data.hq[FB-1:0];
      a_sector <= in_data.hq[hsvg_pkg::HUE_BITS-1:FB];
    end
  end

  // Stage B logic
  assign sf      = {{(LB-CB){1'b0}}, a_s} * {{(LB-FB){1'b0}}, a_f};
  assign om      = hsvg_pkg::CHAN_MAX - a_s;
  assign p1_prod = {{VB{1'b0}}, a_v} * {{VB{1'b0}}, om};

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (b_rdy) begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (b_rdy && a_vld) begin
      b_v      <= a_v;
      b_sf     <= sf;
      b_om     <= om;
      b_p1     <= p1_prod[2*VB-1:VB];
      b_sector <= a_sector;
    end
  end

  // Stage C logic: falling and rising edge products, then pick channels
  assign d2    = hsvg_pkg::FULL_SCALE - b_sf;
  assign d3    = {b_om, {FB{1'b0}}} + b_sf;
  assign prod2 = {{LB{1'b0}}, b_v} * {{VB{1'b0}}, d2};
  assign prod3 = {{LB{1'b0}}, b_v} * {{VB{1'b0}}, d3};
  assign p2    = prod2[PB-1 -: CB];
  assign p3    = prod3[PB-1 -: CB];

  always_comb begin
    case (b_sector)
      hsvg_pkg::SEC_RED_YELLOW:   pix_next = '{red: b_v,  green: p3,   blue: b_p1};
      hsvg_pkg::SEC_YELLOW_GREEN: pix_next = '{red: p2,   green: b_v,  blue: b_p1};
      hsvg_pkg::SEC_GREEN_CYAN:   pix_next = '{red: b_p1, green: b_v,  blue: p3};
      hsvg_pkg::SEC_CYAN_BLUE:    pix_next = '{red: b_p1, green: p2,   blue: b_v};
      hsvg_pkg::SEC_BLUE_MAGENTA: pix_next = '{red: p3,   green: b_p1, blue: b_v};
      default:                    pix_next = '{red: b_v,  green: b_p1, blue: p2};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (c_rdy) begin
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (c_rdy && b_vld) begin
      c_pix <= pix_next;
    end
  end

  assign out_valid = c_vld;
  assign out_data  = c_pix;

  // Saturation never reaches zero, so the low product stays under the value
  `HSVG_ASSERT(a_sat_nonzero, clk, rst, a_vld |-> a_s != '0, "saturation hit zero")
  `HSVG_ASSERT(a_p1_bound, clk, rst, b_vld |-> b_p1 <= b_v, "low product exceeds value")

endmodule

// ===== rtl/core/hsv_gradient_pixel_generator_unit.sv =====
// Top level of the HSV test-field pixel generator.
`timescale 1ns / 1ps

//  channel   direction  handshake              payload
//  cfg       in         cfg_wen                cfg_index, cfg_data
//  in        in         in_valid / in_ready    in_data  (column, row)
//  out       out        out_valid / out_ready  out_data (red, green, blue)
//
//  One pixel per cycle sustained while the output is not stalled; stages from request to result:
//  one clamp stage, four divider stages (4 hue and 2 brightness quotient bits each),
//  then saturation, product and output stages.
//  Synchronous reset empties the pipeline and loads 256 into both size registers.
//  A stall at the output holds the full stages; empty stages still fill,
//  so new requests are taken while a result waits.

`include "assert_macros.svh"

module hsv_gradient_pixel_generator_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wen,
  input  logic                                 cfg_index,
  input  logic [hsvg_pkg::SIZE_BITS-1:0]       cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  hsvg_pkg::pixel_in_t                  in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output hsvg_pkg::pixel_out_t                 out_data
);

  localparam int NS = hsvg_pkg::DIV_STAGES;
  localparam int CB = hsvg_pkg::COORD_BITS;
  localparam int SB = hsvg_pkg::SIZE_BITS;
  localparam int XB = hsvg_pkg::SIX_BITS;

  logic [SB-1:0]   field_width;
  logic [SB-1:0]   field_height;
  hsvg_pkg::dims_t dims;

  logic [CB-1:0]   xc;
  logic [CB-1:0]   yc;
  logic [XB-1:0]   six_x;
  hsvg_pkg::div_t  init;

  logic            d_vld  [NS+1];
  logic            d_rdy  [NS+1];
  hsvg_pkg::div_t  d_data [NS+1];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      field_width  <= hsvg_pkg::SIZE_RESET;
      field_height <= hsvg_pkg::SIZE_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        hsvg_pkg::REG_FIELD_WIDTH:  field_width  <= cfg_data;
        hsvg_pkg::REG_FIELD_HEIGHT: field_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // A zero size acts as one
  assign dims.width  = (field_width  == '0) ? SB'(1) : field_width;
  assign dims.height = (field_height == '0) ? SB'(1) : field_height;

  // Clamp coordinates to the field and set up both dividends
  always_comb begin
    if ({1'b0, in_data.column} >= dims.width) begin
      xc = CB'(dims.width - SB'(1));
    end else begin
      xc = in_data.column;
    end
    if ({1'b0, in_data.row} >= dims.height) begin
      yc = CB'(dims.height - SB'(1));
    end else begin
      yc = in_data.row;
    end
    six_x     = {1'b0, xc, 2'b00} + {2'b00, xc, 1'b0};
    init.hrem = SB'(six_x[XB-1:3]);
    init.hq   = '0;
    init.tail = {six_x[2:0], {(hsvg_pkg::HUE_BITS-3){1'b0}}};
    init.vrem = SB'(yc);
    init.vq   = '0;
  end

  // Input stage
  assign in_ready = !d_vld[0] || d_rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld[0] <= 1'b0;
    end else if (in_ready) begin
      d_vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      d_data[0] <= init;
    end
  end

  // Divider pipeline
  for (genvar k = 0; k < NS; k++) begin : g_div
    hsvg_div_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .dims      (dims),
      .in_valid  (d_vld[k]),
      .in_ready  (d_rdy[k]),
      .in_data   (d_data[k]),
      .out_valid (d_vld[k+1]),
      .out_ready (d_rdy[k+1]),
      .out_data  (d_data[k+1])
    );
  end

  // Colour conversion and output register
  hsvg_colour u_colour (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_vld[NS]),
    .in_ready  (d_rdy[NS]),
    .in_data   (d_data[NS]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Input back-pressure only when every stage is full behind a stalled result
  `HSVG_ASSERT(a_stall_chain, clk, rst, !in_ready |-> out_valid && !out_ready, "stall with room")
  `HSVG_ASSERT_NR(a_reset_empty, clk, rst |=> !out_valid, "result present after reset")

endmodule
